/* src/infix_expression_evaluator_top_defines.svh */
// ----------------------------------------------------------------------------
// Infix expression evaluator assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef INFIX_EXPRESSION_EVALUATOR_TOP_DEFINES_SVH
`define INFIX_EXPRESSION_EVALUATOR_TOP_DEFINES_SVH

// Checks the consequent in the cycle after the antecedent, outside reset.
`define IEE_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("infix evaluator port check failed");

// Checks the consequent in the same cycle, including during reset.
`define IEE_ASSERT_NOW(label, clk, cond, expr) \
    label: assert property (@(posedge clk) (cond) |-> (expr)) \
        else $error("infix evaluator port check failed");

`endif

/* src/iee_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Infix expression evaluator package
// Item types, character codes and state encodings shared by the block.
// ----------------------------------------------------------------------------
package iee_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;

    localparam logic [3:0] DECIMAL_BASE = 4'd10;

    typedef enum logic [1:0] {
        KIND_IGNORE,
        KIND_DIGIT,
        KIND_ADD_SUB,
        KIND_MUL_DIV
    } kind_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_MUL,
        OP_DIV
    } pend_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_END,
        ST_OUT
    } back_state_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_expression;
    } char_item_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic               divide_by_zero;
    } result_item_t;

    // alt: subtract for KIND_ADD_SUB, divide for KIND_MUL_DIV.
    typedef struct packed {
        kind_t      kind;
        logic [3:0] digit;
        logic       alt;
        logic       last;
    } op_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

/* src/iee_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Infix expression evaluator front end
// Accepts characters, classifies them and pushes operations to the queue.
// ----------------------------------------------------------------------------
module iee_front
(
    input  logic                  char_valid,
    output logic                  char_ready,
    input  iee_pkg::char_item_t   char_item,
    input  iee_pkg::queue_status_t queue_status,
    output logic                  push,
    output iee_pkg::op_item_t     push_item
);

    logic [7:0] digit_offset;

    always_comb
    begin
        digit_offset        = char_item.char_code - iee_pkg::CHAR_ZERO;
        push_item.digit     = digit_offset[3:0];
        push_item.last      = char_item.end_of_expression;
        push_item.alt       = 1'b0;
        push_item.kind      = iee_pkg::KIND_IGNORE;
        if (char_item.char_code >= iee_pkg::CHAR_ZERO &&
            char_item.char_code <= iee_pkg::CHAR_NINE)
        begin
            push_item.kind = iee_pkg::KIND_DIGIT;
        end
        else if (char_item.char_code == iee_pkg::CHAR_PLUS ||
                 char_item.char_code == iee_pkg::CHAR_MINUS)
        begin
            push_item.kind = iee_pkg::KIND_ADD_SUB;
            push_item.alt  = (char_item.char_code == iee_pkg::CHAR_MINUS);
        end
        else if (char_item.char_code == iee_pkg::CHAR_STAR ||
                 char_item.char_code == iee_pkg::CHAR_SLASH)
        begin
            push_item.kind = iee_pkg::KIND_MUL_DIV;
            push_item.alt  = (char_item.char_code == iee_pkg::CHAR_SLASH);
        end
    end

    assign char_ready = !queue_status.full;

    // Ignored characters carry no work unless they close the expression.
    assign push = char_valid && char_ready &&
                  (push_item.kind != iee_pkg::KIND_IGNORE || push_item.last);

endmodule

/* src/iee_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Infix expression evaluator operation queue
// Short first-in first-out buffer between the front and back ends.
// ----------------------------------------------------------------------------
module iee_queue
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  iee_pkg::op_item_t      push_item,
    input  logic                   pop,
    output iee_pkg::op_item_t      head_item,
    output iee_pkg::queue_status_t queue_status
);

    localparam int PTR_W = $clog2(iee_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(iee_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(iee_pkg::QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(iee_pkg::QUEUE_DEPTH);

    iee_pkg::op_item_t entry_reg [iee_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head_item          = entry_reg[rd_ptr_reg];
    assign queue_status.full  = (count_reg == FULL_CNT);
    assign queue_status.empty = (count_reg == '0);

endmodule

/* src/iee_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Infix expression evaluator back end
// Sequencer with a shared shift-add multiplier and restoring divider.
// ----------------------------------------------------------------------------
module iee_back
#(
    parameter int DATA_WIDTH = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  iee_pkg::queue_status_t queue_status,
    input  iee_pkg::op_item_t      head_item,
    output logic                   pop,
    output logic                   result_valid,
    input  logic                   result_ready,
    output iee_pkg::result_item_t  result_item
);

    localparam int CNT_W = $clog2(DATA_WIDTH);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DATA_WIDTH - 1);

    iee_pkg::back_state_t state_reg;
    iee_pkg::back_state_t state_next;
    logic [DATA_WIDTH-1:0] total_reg;
    logic [DATA_WIDTH-1:0] total_next;
    logic [DATA_WIDTH-1:0] cur_reg;
    logic [DATA_WIDTH-1:0] cur_next;
    logic [DATA_WIDTH-1:0] pf_reg;
    logic [DATA_WIDTH-1:0] pf_next;
    logic                  neg_reg;
    logic                  neg_next;
    iee_pkg::pend_op_t     op_reg;
    iee_pkg::pend_op_t     op_next;
    logic                  err_reg;
    logic                  err_next;
    iee_pkg::op_item_t     item_reg;
    iee_pkg::op_item_t     item_next;
    logic                  fin_reg;
    logic                  fin_next;
    logic [DATA_WIDTH-1:0] acc_reg;
    logic [DATA_WIDTH-1:0] acc_next;
    logic [DATA_WIDTH-1:0] a_reg;
    logic [DATA_WIDTH-1:0] a_next;
    logic [DATA_WIDTH-1:0] b_reg;
    logic [DATA_WIDTH-1:0] b_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic                  sign_reg;
    logic                  sign_next;
    logic                  res_valid_reg;
    logic                  res_valid_next;
    iee_pkg::result_item_t res_item_reg;
    iee_pkg::result_item_t res_item_next;

    iee_pkg::op_item_t     item_sel;
    logic                  fin_sel;
    logic                  start_apply;
    logic                  commit_en;
    logic [DATA_WIDTH-1:0] commit_val;
    logic [DATA_WIDTH-1:0] mag_pf;
    logic [DATA_WIDTH-1:0] mag_cur;
    logic [DATA_WIDTH-1:0] mul_sum;
    logic [DATA_WIDTH:0]   trial;
    logic [DATA_WIDTH:0]   diff;
    logic [DATA_WIDTH-1:0] quot;

    always_comb
    begin
        state_next     = state_reg;
        total_next     = total_reg;
        cur_next       = cur_reg;
        pf_next        = pf_reg;
        neg_next       = neg_reg;
        op_next        = op_reg;
        err_next       = err_reg;
        item_next      = item_reg;
        fin_next       = fin_reg;
        acc_next       = acc_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        cnt_next       = cnt_reg;
        sign_next      = sign_reg;
        res_valid_next = res_valid_reg && !result_ready;
        res_item_next  = res_item_reg;
        pop            = 1'b0;
        start_apply    = 1'b0;
        commit_en      = 1'b0;
        commit_val     = '0;

        mag_pf  = pf_reg[DATA_WIDTH-1] ? ({DATA_WIDTH{1'b0}} - pf_reg) : pf_reg;
        mag_cur = cur_reg[DATA_WIDTH-1] ? ({DATA_WIDTH{1'b0}} - cur_reg) : cur_reg;
        mul_sum = acc_reg + (b_reg[0] ? a_reg : {DATA_WIDTH{1'b0}});
        trial   = {acc_reg, b_reg[DATA_WIDTH-1]};
        diff    = trial - {1'b0, a_reg};
        quot    = {b_reg[DATA_WIDTH-2:0], ~diff[DATA_WIDTH]};

        item_sel = (state_reg == iee_pkg::ST_IDLE) ? head_item : item_reg;
        fin_sel  = (state_reg == iee_pkg::ST_END) ||
                   (fin_reg && state_reg != iee_pkg::ST_IDLE);

        case (state_reg)
            iee_pkg::ST_IDLE:
            begin
                if (!queue_status.empty)
                begin
                    pop       = 1'b1;
                    item_next = head_item;
                    fin_next  = 1'b0;
                    case (head_item.kind)
                        iee_pkg::KIND_DIGIT:
                        begin
                            cur_next = cur_reg * DATA_WIDTH'(iee_pkg::DECIMAL_BASE)
                                     + DATA_WIDTH'(head_item.digit);
                            if (head_item.last)
                            begin
                                state_next = iee_pkg::ST_END;
                            end
                        end
                        iee_pkg::KIND_ADD_SUB,
                        iee_pkg::KIND_MUL_DIV:
                        begin
                            start_apply = 1'b1;
                        end
                        default:
                        begin
                            if (head_item.last)
                            begin
                                state_next = iee_pkg::ST_END;
                            end
                        end
                    endcase
                end
            end
            iee_pkg::ST_END:
            begin
                fin_next = 1'b1;
                // A zero operand at the end leaves the pending term out.
                if (cur_reg != '0)
                begin
                    start_apply = 1'b1;
                end
                else
                begin
                    state_next = iee_pkg::ST_OUT;
                end
            end
            iee_pkg::ST_MUL:
            begin
                acc_next = mul_sum;
                a_next   = a_reg << 1;
                b_next   = b_reg >> 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    commit_en  = 1'b1;
                    commit_val = mul_sum;
                end
            end
            iee_pkg::ST_DIV:
            begin
                acc_next = diff[DATA_WIDTH] ? trial[DATA_WIDTH-1:0] : diff[DATA_WIDTH-1:0];
                b_next   = quot;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    commit_en  = 1'b1;
                    commit_val = sign_reg ? ({DATA_WIDTH{1'b0}} - quot) : quot;
                end
            end
            iee_pkg::ST_OUT:
            begin
                if (!res_valid_reg || result_ready)
                begin
                    res_valid_next               = 1'b1;
                    res_item_next.value          = 32'($signed(total_reg));
                    res_item_next.divide_by_zero = err_reg;
                    total_next                   = '0;
                    cur_next                     = '0;
                    pf_next                      = '0;
                    neg_next                     = 1'b0;
                    op_next                      = iee_pkg::OP_NONE;
                    err_next                     = 1'b0;
                    state_next                   = iee_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = iee_pkg::ST_IDLE;
            end
        endcase

        if (start_apply)
        begin
            case (op_reg)
                iee_pkg::OP_MUL:
                begin
                    acc_next   = '0;
                    a_next     = pf_reg;
                    b_next     = cur_reg;
                    cnt_next   = LAST_STEP;
                    state_next = iee_pkg::ST_MUL;
                end
                iee_pkg::OP_DIV:
                begin
                    if (mag_cur == '0)
                    begin
                        err_next   = 1'b1;
                        commit_en  = 1'b1;
                        commit_val = '0;
                    end
                    else
                    begin
                        acc_next   = '0;
                        a_next     = mag_cur;
                        b_next     = mag_pf;
                        sign_next  = pf_reg[DATA_WIDTH-1] ^ cur_reg[DATA_WIDTH-1];
                        cnt_next   = LAST_STEP;
                        state_next = iee_pkg::ST_DIV;
                    end
                end
                default:
                begin
                    commit_en  = 1'b1;
                    commit_val = cur_reg;
                end
            endcase
        end

        if (commit_en)
        begin
            if (fin_sel || item_sel.kind == iee_pkg::KIND_ADD_SUB)
            begin
                total_next = neg_reg ? (total_reg - commit_val) : (total_reg + commit_val);
            end
            if (fin_sel)
            begin
                state_next = iee_pkg::ST_OUT;
            end
            else
            begin
                if (item_sel.kind == iee_pkg::KIND_ADD_SUB)
                begin
                    neg_next = item_sel.alt;
                    op_next  = iee_pkg::OP_NONE;
                end
                else
                begin
                    pf_next = commit_val;
                    op_next = item_sel.alt ? iee_pkg::OP_DIV : iee_pkg::OP_MUL;
                end
                cur_next   = '0;
                state_next = item_sel.last ? iee_pkg::ST_END : iee_pkg::ST_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= iee_pkg::ST_IDLE;
            total_reg     <= '0;
            cur_reg       <= '0;
            pf_reg        <= '0;
            neg_reg       <= 1'b0;
            op_reg        <= iee_pkg::OP_NONE;
            err_reg       <= 1'b0;
            fin_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            cur_reg       <= cur_next;
            pf_reg        <= pf_next;
            neg_reg       <= neg_next;
            op_reg        <= op_next;
            err_reg       <= err_next;
            fin_reg       <= fin_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        acc_reg      <= acc_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        cnt_reg      <= cnt_next;
        sign_reg     <= sign_next;
        res_item_reg <= res_item_next;
    end

    assign result_valid = res_valid_reg;
    assign result_item  = res_item_reg;

endmodule

/* src/infix_expression_evaluator_top.sv */
`timescale 1ns / 1ps
// The back end takes a queue item only when idle; a digit or ignored character is
// consumed there. An operator is applied there unless a * or / is pending, which
// first runs the shift-add multiplier or restoring divider; a zero divisor is
// flagged without dividing. At the end the pending term is applied unless the last
// operand is zero, then the result is registered. A four-entry queue decouples input.
// Reset is asynchronous and clears the control registers; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Infix expression evaluator top level
// Evaluates + - * / expressions arriving one character per item.
// ----------------------------------------------------------------------------
module infix_expression_evaluator_top
#(
    parameter int DATA_WIDTH = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  char_valid,
    output logic                  char_ready,
    input  iee_pkg::char_item_t   char_item,
    output logic                  result_valid,
    input  logic                  result_ready,
    output iee_pkg::result_item_t result_item
);

    iee_pkg::queue_status_t queue_status;
    iee_pkg::op_item_t      push_item;
    iee_pkg::op_item_t      head_item;
    logic                   push;
    logic                   pop;

    iee_front u_front
    (
        .char_valid   (char_valid),
        .char_ready   (char_ready),
        .char_item    (char_item),
        .queue_status (queue_status),
        .push         (push),
        .push_item    (push_item)
    );

    iee_queue u_queue
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .push_item    (push_item),
        .pop          (pop),
        .head_item    (head_item),
        .queue_status (queue_status)
    );

    iee_back #(.DATA_WIDTH(DATA_WIDTH)) u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .queue_status (queue_status),
        .head_item    (head_item),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_item  (result_item)
    );

endmodule

/* src/iee_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Infix expression evaluator port checker
// Concurrent checks on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "infix_expression_evaluator_top_defines.svh"

module iee_checker
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  char_valid,
    input logic                  char_ready,
    input iee_pkg::char_item_t   char_item,
    input logic                  result_valid,
    input logic                  result_ready,
    input iee_pkg::result_item_t result_item
);

    logic unused_inputs;

    assign unused_inputs = char_valid ^ (^char_item);

    // A stalled result item stays offered.
    `IEE_ASSERT_NEXT(a_result_held, clk, rst_n, result_valid && !result_ready, result_valid)

    // A stalled result item keeps its value and error flag.
    `IEE_ASSERT_NEXT(a_result_stable, clk, rst_n, result_valid && !result_ready, $stable(result_item))

    // Reset empties the queue and the output register together.
    `IEE_ASSERT_NOW(a_reset_clear, clk, !rst_n && $past(!rst_n), char_ready && !result_valid && !unused_inputs || char_ready && !result_valid)

    // No result can appear in the first cycle after reset is released.
    `IEE_ASSERT_NOW(a_no_early_result, clk, $past(!rst_n), !result_valid)

endmodule

bind infix_expression_evaluator_top iee_checker u_iee_checker (.*);
